FILE: rtl/dmc_pkg.sv
// Shared types, constants and helper functions for the maze carver.
`timescale 1ns / 1ps
`default_nettype none

package dmc_pkg;

	localparam int GRID_COLS_DEF   = 32;
	localparam int GRID_ROWS_DEF   = 32;
	localparam int STACK_DEPTH_DEF = 256;

	localparam int COORD_W   = 5;
	localparam int COORD_LIM = 32;
	localparam int RAND_W    = 16;
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 1;
	localparam int ENTRY_W   = 2 * COORD_W;

	localparam logic [CFG_W-1:0] BOUND_RESET = 6'd32;

	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

	localparam logic [1:0] FN_CLEAR = 2'd0;
	localparam logic [1:0] FN_START = 2'd1;

	localparam logic signed [2:0] STEP_DX [4] = '{3'sd2, -3'sd2, 3'sd0, 3'sd0};
	localparam logic signed [2:0] STEP_DY [4] = '{3'sd0, 3'sd0, 3'sd2, -3'sd2};

	typedef enum logic [2:0] {
		EV_CLEARED     = 3'd0,
		EV_STARTED     = 3'd1,
		EV_CARVED      = 3'd2,
		EV_BACKTRACKED = 3'd3,
		EV_FINISHED    = 3'd4
	} dmc_ev_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DECODE,
		S_CLEAR,
		S_START,
		S_TOP,
		S_RD0,
		S_RD1,
		S_RD2,
		S_RD3,
		S_EVAL,
		S_PICK,
		S_WALL,
		S_TARGET,
		S_DONE
	} dmc_state_t;

	typedef struct packed {
		logic [1:0]         func;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [RAND_W-1:0]  rand_word;
	} dmc_item_t;

	typedef struct packed {
		logic [2:0]         event_res;
		logic [COORD_W-1:0] wall_x;
		logic [COORD_W-1:0] wall_y;
		logic [COORD_W-1:0] target_x;
		logic [COORD_W-1:0] target_y;
		logic               stack_empty;
	} dmc_res_t;

	typedef struct packed {
		logic       latch;
		logic       clr_we;
		logic       wr_start;
		logic       stk_rd;
		logic       nb_rd;
		logic [1:0] rd_dir;
		logic       nb_cap;
		logic [1:0] cap_dir;
		logic       pick;
		logic       wr_wall;
		logic       wr_target;
		logic       pop;
		logic       out_load;
		dmc_ev_t    ev;
	} dmc_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       stack_empty;
		logic       clr_last;
		logic       any_cand;
	} dmc_sts_t;

	// Remainder modulo three: base-four digits are summed, then folded.
	function automatic logic [1:0] mod3_16(input logic [RAND_W-1:0] v);
		logic [4:0] s;
		logic [2:0] t;
		s = '0;
		for (int i = 0; i < RAND_W / 2; i++) begin
			s = s + 5'(v[2*i +: 2]);
		end
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		if (t >= 3'd6) begin
			t = t - 3'd6;
		end else if (t >= 3'd3) begin
			t = t - 3'd3;
		end
		return t[1:0];
	endfunction

	// Direction of the k-th set candidate bit, counted from direction zero.
	function automatic logic [1:0] pick_dir(input logic [3:0] cand, input logic [1:0] k);
		logic [1:0] seen;
		logic [1:0] d;
		logic       found;
		seen  = '0;
		d     = '0;
		found = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (cand[i] && !found) begin
				if (seen == k) begin
					d     = 2'(i);
					found = 1'b1;
				end else begin
					seen = seen + 2'd1;
				end
			end
		end
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/dfs_maze_carver.sv
// Top level of the depth-first maze carver.
`timescale 1ns / 1ps
`default_nettype none

// Carves a maze one request at a time on a grid held in a row-wide memory, with the
// visit stack in a second memory. After reset the block sweeps the grid to walls,
// one row per cycle, before it takes its first request; a clear request repeats
// that sweep. A carving step reads the stack top and then the four neighbor cells
// one at a time through the single grid read port, and makes two single-cell writes
// when it carves and none when it backtracks. A finished result waits in an output
// register, and the next request is taken while it waits. Configuration writes are
// always ready.
module dfs_maze_carver #(
	parameter int GRID_COLS   = dmc_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS   = dmc_pkg::GRID_ROWS_DEF,
	parameter int STACK_DEPTH = dmc_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire dmc_pkg::dmc_item_t            item,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output dmc_pkg::dmc_res_t                  res,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [dmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dmc_pkg::CFG_W-1:0]     cfg_data
);

	dmc_pkg::dmc_cmd_t cmd;
	dmc_pkg::dmc_sts_t sts;

	assign cfg_ready = 1'b1;

	dmc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	dmc_datapath #(
		.GRID_COLS   (GRID_COLS),
		.GRID_ROWS   (GRID_ROWS),
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res)
	);

endmodule

`default_nettype wire

FILE: rtl/dmc_ctrl.sv
// Sequencing state machine of the maze carver.
`timescale 1ns / 1ps
`default_nettype none

module dmc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_ready,
	output logic                 res_valid,
	input  wire logic            res_ready,
	input  wire dmc_pkg::dmc_sts_t sts,
	output dmc_pkg::dmc_cmd_t    cmd
);

	dmc_pkg::dmc_state_t state_q, state_d;
	dmc_pkg::dmc_ev_t    ev_q, ev_d;
	logic                res_valid_q;
	logic                out_free;

	assign out_free   = !res_valid_q || res_ready;
	assign res_valid  = res_valid_q;
	assign item_ready = (state_q == dmc_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dmc_pkg::S_INIT;
			ev_q        <= dmc_pkg::EV_CLEARED;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ev_q    <= ev_d;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		ev_d    = ev_q;
		cmd     = '0;
		cmd.ev  = ev_q;
		case (state_q)
			dmc_pkg::S_INIT: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_last) begin
					state_d = dmc_pkg::S_IDLE;
				end
			end
			dmc_pkg::S_IDLE: begin
				if (item_valid) begin
					cmd.latch = 1'b1;
					state_d   = dmc_pkg::S_DECODE;
				end
			end
			dmc_pkg::S_DECODE: begin
				case (sts.func)
					dmc_pkg::FN_CLEAR: state_d = dmc_pkg::S_CLEAR;
					dmc_pkg::FN_START: state_d = dmc_pkg::S_START;
					default: begin
						if (sts.stack_empty) begin
							ev_d    = dmc_pkg::EV_FINISHED;
							state_d = dmc_pkg::S_DONE;
						end else begin
							state_d = dmc_pkg::S_TOP;
						end
					end
				endcase
			end
			dmc_pkg::S_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_last) begin
					ev_d    = dmc_pkg::EV_CLEARED;
					state_d = dmc_pkg::S_DONE;
				end
			end
			dmc_pkg::S_START: begin
				cmd.wr_start = 1'b1;
				ev_d         = dmc_pkg::EV_STARTED;
				state_d      = dmc_pkg::S_DONE;
			end
			dmc_pkg::S_TOP: begin
				cmd.stk_rd = 1'b1;
				state_d    = dmc_pkg::S_RD0;
			end
			dmc_pkg::S_RD0: begin
				cmd.nb_rd  = 1'b1;
				cmd.rd_dir = 2'd0;
				state_d    = dmc_pkg::S_RD1;
			end
			dmc_pkg::S_RD1: begin
				cmd.nb_rd   = 1'b1;
				cmd.rd_dir  = 2'd1;
				cmd.nb_cap  = 1'b1;
				cmd.cap_dir = 2'd0;
				state_d     = dmc_pkg::S_RD2;
			end
			dmc_pkg::S_RD2: begin
				cmd.nb_rd   = 1'b1;
				cmd.rd_dir  = 2'd2;
				cmd.nb_cap  = 1'b1;
				cmd.cap_dir = 2'd1;
				state_d     = dmc_pkg::S_RD3;
			end
			dmc_pkg::S_RD3: begin
				cmd.nb_rd   = 1'b1;
				cmd.rd_dir  = 2'd3;
				cmd.nb_cap  = 1'b1;
				cmd.cap_dir = 2'd2;
				state_d     = dmc_pkg::S_EVAL;
			end
			dmc_pkg::S_EVAL: begin
				cmd.nb_cap  = 1'b1;
				cmd.cap_dir = 2'd3;
				state_d     = dmc_pkg::S_PICK;
			end
			dmc_pkg::S_PICK: begin
				if (sts.any_cand) begin
					cmd.pick = 1'b1;
					state_d  = dmc_pkg::S_WALL;
				end else begin
					cmd.pop = 1'b1;
					ev_d    = dmc_pkg::EV_BACKTRACKED;
					state_d = dmc_pkg::S_DONE;
				end
			end
			dmc_pkg::S_WALL: begin
				cmd.wr_wall = 1'b1;
				state_d     = dmc_pkg::S_TARGET;
			end
			dmc_pkg::S_TARGET: begin
				cmd.wr_target = 1'b1;
				ev_d          = dmc_pkg::EV_CARVED;
				state_d       = dmc_pkg::S_DONE;
			end
			dmc_pkg::S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = dmc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dmc_pkg::S_INIT;
			end
		endcase
	end

	// A result is never loaded over one that has not been taken.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!res_valid_q || res_ready))
		else $error("result register overwritten");

	// A pending result stays visible until it is taken.
	a_res_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ready) |=> res_valid_q)
		else $error("pending result dropped");

endmodule

`default_nettype wire

FILE: rtl/dmc_datapath.sv
// Grid memory, visit stack, neighbor evaluation and result register of the maze carver.
`timescale 1ns / 1ps
`default_nettype none

module dmc_datapath #(
	parameter int GRID_COLS   = dmc_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS   = dmc_pkg::GRID_ROWS_DEF,
	parameter int STACK_DEPTH = dmc_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire dmc_pkg::dmc_item_t             item,
	input  wire logic                           cfg_valid,
	input  wire logic [dmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dmc_pkg::CFG_W-1:0]      cfg_data,
	input  wire dmc_pkg::dmc_cmd_t              cmd,
	output dmc_pkg::dmc_sts_t                   sts,
	output dmc_pkg::dmc_res_t                   res
);

	localparam int ROW_W = $clog2(GRID_ROWS);
	localparam int COL_W = $clog2(GRID_COLS);
	localparam int SP_W  = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam logic [dmc_pkg::CFG_W-1:0] COL_LIM =
		dmc_pkg::CFG_W'((GRID_COLS < dmc_pkg::COORD_LIM) ? GRID_COLS : dmc_pkg::COORD_LIM);
	localparam logic [dmc_pkg::CFG_W-1:0] ROW_LIM =
		dmc_pkg::CFG_W'((GRID_ROWS < dmc_pkg::COORD_LIM) ? GRID_ROWS : dmc_pkg::COORD_LIM);

	logic [GRID_COLS-1:0]          grid_mem [GRID_ROWS];
	logic [dmc_pkg::ENTRY_W-1:0]   stack_mem [STACK_DEPTH];

	dmc_pkg::dmc_item_t            req_q;
	logic [dmc_pkg::CFG_W-1:0]     cols_q, rows_q;
	logic [dmc_pkg::CFG_W-1:0]     cols_b, rows_b;
	logic [ROW_W-1:0]              clr_row_q;
	logic                          clr_last;
	logic [CNT_W-1:0]              stk_cnt_q;
	logic [CNT_W-1:0]              cnt_m1;
	logic                          stk_full;
	logic [dmc_pkg::ENTRY_W-1:0]   stk_rd_q;
	logic                          grid_rd_q;
	logic [3:0]                    cand_q;
	logic [1:0]                    dir_q;
	logic [1:0]                    sel_k;
	logic [2:0]                    n_cand;
	logic [dmc_pkg::COORD_W-1:0]   cx, cy;
	logic [6:0]                    nx [4];
	logic [6:0]                    ny [4];
	logic [6:0]                    wx [4];
	logic [6:0]                    wy [4];
	logic [3:0]                    inb;
	logic                          start_inb;
	logic                          bit_we;
	logic [6:0]                    w_x, w_y;
	logic                          push_en;
	logic [dmc_pkg::ENTRY_W-1:0]   push_data;
	dmc_pkg::dmc_res_t             res_q;

	assign cols_b    = (cols_q > COL_LIM) ? COL_LIM : cols_q;
	assign rows_b    = (rows_q > ROW_LIM) ? ROW_LIM : rows_q;
	assign cx        = stk_rd_q[dmc_pkg::COORD_W-1:0];
	assign cy        = stk_rd_q[dmc_pkg::ENTRY_W-1:dmc_pkg::COORD_W];
	assign clr_last  = (clr_row_q == ROW_W'(GRID_ROWS - 1));
	assign stk_full  = (stk_cnt_q == CNT_W'(STACK_DEPTH));
	assign cnt_m1    = stk_cnt_q - CNT_W'(1);
	assign start_inb = ({1'b0, req_q.start_x} < cols_b) && ({1'b0, req_q.start_y} < rows_b);

	// Neighbor, wall and bounds for all four directions around the stack top.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			nx[i]  = {2'b00, cx} + {{4{dmc_pkg::STEP_DX[i][2]}}, dmc_pkg::STEP_DX[i]};
			ny[i]  = {2'b00, cy} + {{4{dmc_pkg::STEP_DY[i][2]}}, dmc_pkg::STEP_DY[i]};
			wx[i]  = {2'b00, cx} + {{5{dmc_pkg::STEP_DX[i][2]}}, dmc_pkg::STEP_DX[i][2:1]};
			wy[i]  = {2'b00, cy} + {{5{dmc_pkg::STEP_DY[i][2]}}, dmc_pkg::STEP_DY[i][2:1]};
			inb[i] = (nx[i] < {1'b0, cols_b}) && (ny[i] < {1'b0, rows_b});
		end
	end

	always_comb begin
		n_cand = 3'(cand_q[0]) + 3'(cand_q[1]) + 3'(cand_q[2]) + 3'(cand_q[3]);
		case (n_cand)
			3'd1:    sel_k = 2'd0;
			3'd2:    sel_k = {1'b0, req_q.rand_word[0]};
			3'd3:    sel_k = dmc_pkg::mod3_16(req_q.rand_word);
			default: sel_k = req_q.rand_word[1:0];
		endcase
	end

	always_comb begin
		bit_we = 1'b0;
		w_x    = '0;
		w_y    = '0;
		if (cmd.wr_start && start_inb) begin
			bit_we = 1'b1;
			w_x    = {2'b00, req_q.start_x};
			w_y    = {2'b00, req_q.start_y};
		end else if (cmd.wr_wall) begin
			bit_we = 1'b1;
			w_x    = wx[dir_q];
			w_y    = wy[dir_q];
		end else if (cmd.wr_target) begin
			bit_we = 1'b1;
			w_x    = nx[dir_q];
			w_y    = ny[dir_q];
		end
	end

	assign push_en   = ((cmd.wr_start && start_inb) || cmd.wr_target) && !stk_full;
	assign push_data = cmd.wr_target
		? {ny[dir_q][dmc_pkg::COORD_W-1:0], nx[dir_q][dmc_pkg::COORD_W-1:0]}
		: {req_q.start_y, req_q.start_x};

	always_ff @(posedge clk) begin
		if (cmd.clr_we) begin
			grid_mem[clr_row_q] <= '0;
		end else if (bit_we) begin
			grid_mem[w_y[ROW_W-1:0]][w_x[COL_W-1:0]] <= 1'b1;
		end
		if (cmd.nb_rd) begin
			grid_rd_q <= grid_mem[ny[cmd.rd_dir][ROW_W-1:0]][nx[cmd.rd_dir][COL_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			stack_mem[stk_cnt_q[SP_W-1:0]] <= push_data;
		end
		if (cmd.stk_rd) begin
			stk_rd_q <= stack_mem[cnt_m1[SP_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= item;
		end
		if (cmd.nb_cap) begin
			cand_q[cmd.cap_dir] <= inb[cmd.cap_dir] && !grid_rd_q;
		end
		if (cmd.pick) begin
			dir_q <= dmc_pkg::pick_dir(cand_q, sel_k);
		end
		if (cmd.out_load) begin
			res_q.event_res   <= cmd.ev;
			res_q.stack_empty <= (stk_cnt_q == '0);
			case (cmd.ev)
				dmc_pkg::EV_STARTED: begin
					res_q.wall_x   <= req_q.start_x;
					res_q.wall_y   <= req_q.start_y;
					res_q.target_x <= req_q.start_x;
					res_q.target_y <= req_q.start_y;
				end
				dmc_pkg::EV_CARVED: begin
					res_q.wall_x   <= wx[dir_q][dmc_pkg::COORD_W-1:0];
					res_q.wall_y   <= wy[dir_q][dmc_pkg::COORD_W-1:0];
					res_q.target_x <= nx[dir_q][dmc_pkg::COORD_W-1:0];
					res_q.target_y <= ny[dir_q][dmc_pkg::COORD_W-1:0];
				end
				default: begin
					res_q.wall_x   <= '0;
					res_q.wall_y   <= '0;
					res_q.target_x <= '0;
					res_q.target_y <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q    <= dmc_pkg::BOUND_RESET;
			rows_q    <= dmc_pkg::BOUND_RESET;
			clr_row_q <= '0;
			stk_cnt_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					dmc_pkg::CFG_COLS: cols_q <= cfg_data;
					dmc_pkg::CFG_ROWS: rows_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clr_we) begin
				clr_row_q <= clr_last ? '0 : clr_row_q + ROW_W'(1);
			end
			if (cmd.clr_we) begin
				stk_cnt_q <= '0;
			end else if (push_en) begin
				stk_cnt_q <= stk_cnt_q + CNT_W'(1);
			end else if (cmd.pop) begin
				stk_cnt_q <= cnt_m1;
			end
		end
	end

	assign sts.func        = req_q.func;
	assign sts.stack_empty = (stk_cnt_q == '0);
	assign sts.clr_last    = clr_last;
	assign sts.any_cand    = |cand_q;
	assign res             = res_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stk_cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (stk_cnt_q != '0))
		else $error("pop on empty stack");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push_en |=> (stk_cnt_q == CNT_W'($past(stk_cnt_q) + 1'b1)))
		else $error("push did not advance the stack count");

	a_write_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_we |-> !(cmd.wr_start || cmd.wr_wall || cmd.wr_target))
		else $error("cell write during clearing pass");

endmodule

`default_nettype wire
